// ----- sv/bps_pkg.sv -----
// shared types and codes for the byte pattern search unit
`default_nettype none

package bps_pkg;

    localparam int ADDR_W  = 64;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 6;
    localparam int CFG_W   = 7;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_DATA  = 2'd2
    } opcode_t;

    // one decoded item as it leaves the input register
    typedef struct packed {
        logic               load;
        logic               start;
        logic               data;
        logic [INDEX_W-1:0] index;
        logic [BYTE_W-1:0]  value;
        logic [ADDR_W-1:0]  base;
    } step_t;

endpackage

`default_nettype wire

// ----- sv/bps_pattern_store.sv -----
// pattern byte store, one write port, every entry visible to the comparator
`default_nettype none

module bps_pattern_store
    import bps_pkg::*;
#(
    parameter int MAX_PATTERN = 64
)
(
    input  wire logic                                clk,
    input  wire logic                                wr_en,
    input  wire logic [INDEX_W-1:0]                  wr_index,
    input  wire logic [BYTE_W-1:0]                   wr_value,
    output logic      [MAX_PATTERN-1:0][BYTE_W-1:0]  pattern
);

    logic [MAX_PATTERN-1:0][BYTE_W-1:0] store_reg;

    // an index beyond the store matches no entry and is dropped
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if (wr_en && (32'(wr_index) == k))
            begin
                store_reg[k] <= wr_value;
            end
        end
    end

    assign pattern = store_reg;

endmodule

`default_nettype wire

// ----- sv/bps_matcher.sv -----
// byte window, region tracking and parallel window compare
`default_nettype none

module bps_matcher
    import bps_pkg::*;
#(
    parameter int MAX_PATTERN = 64,
    parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                step_valid,
    input  wire step_t                               step,
    input  wire logic [LEN_W-1:0]                    len,
    input  wire logic [MAX_PATTERN-1:0][BYTE_W-1:0]  pattern,
    output logic                                     match,
    output logic      [ADDR_W-1:0]                   address
);

    logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_reg;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_next;
    logic [LEN_W-1:0]                   count_reg;
    logic [LEN_W-1:0]                   count_next;
    logic [ADDR_W-1:0]                  addr_reg;
    logic [ADDR_W-1:0]                  addr_next;

    logic [MAX_PATTERN-1:0][BYTE_W-1:0] reversed;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] aligned;
    logic [LEN_W-1:0]                   shift_amt;
    logic [MAX_PATTERN-1:0]             byte_ok;

    // addr_reg tracks base plus offset of the next data byte
    always_comb
    begin
        win_next   = win_reg;
        count_next = count_reg;
        addr_next  = addr_reg;
        if (step_valid && step.data)
        begin
            win_next[0] = step.value;
            for (int k = 1; k < MAX_PATTERN; k++)
            begin
                win_next[k] = win_reg[k-1];
            end
            if (count_reg < LEN_W'(MAX_PATTERN))
            begin
                count_next = count_reg + LEN_W'(1);
            end
            addr_next = addr_reg + ADDR_W'(1);
        end
        else if (step_valid && step.start)
        begin
            count_next = '0;
            addr_next  = step.base;
        end
    end

    // oldest byte first, then drop the bytes older than the pattern length
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            reversed[i] = win_next[MAX_PATTERN-1-i];
        end
    end

    assign shift_amt = LEN_W'(MAX_PATTERN) - len;
    assign aligned   = reversed >> {shift_amt, 3'b000};

    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            byte_ok[i] = (aligned[i] == pattern[i]) || (LEN_W'(i) >= len);
        end
    end

    // the count gate keeps bytes of an earlier region out of the compare
    assign match   = step_valid && step.data && (&byte_ok) && (count_next >= len);
    assign address = addr_reg - ADDR_W'(len - LEN_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            addr_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            addr_reg  <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

`default_nettype wire

// ----- sv/byte_pattern_search_all_matches_unit.sv -----
// Top level of the byte pattern search unit.
// Input channel (in_valid/in_ready): one transaction per item, with opcode
// load pattern byte, start region (region_base) or data byte (byte_value).
// Output channel (out_valid/out_ready): one transaction per match, giving
// match_address, the absolute address of the first byte of the occurrence.
// Overlapping occurrences each give their own transaction.
// Config channel (cfg_valid/cfg_ready): writes pattern_length, always ready;
// write it only while no transaction is in flight. 0 acts as 1, values above
// MAX_PATTERN act as MAX_PATTERN.
// Throughput is one item per cycle while the receiver does not stall. A match
// appears on out_valid once its data byte has passed the input register and
// the result register has loaded the result. Between the two registers lies
// the combinational window compare (aligning shifter plus MAX_PATTERN byte
// comparators and an and-tree).
// When the receiver stalls with a result waiting, the input register holds
// and in_ready falls once it is occupied; nothing is dropped.
// Reset clears the length to 1, the region to base zero and all valid
// flags; pattern bytes are undefined until loaded.
`default_nettype none

module byte_pattern_search_all_matches_unit
    import bps_pkg::*;
#(
    parameter int MAX_PATTERN = 64
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          opcode,
    input  wire logic [INDEX_W-1:0]  pattern_index,
    input  wire logic [BYTE_W-1:0]   byte_value,
    input  wire logic [ADDR_W-1:0]   region_base,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic      [ADDR_W-1:0]   match_address,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CFG_W-1:0]    pattern_length
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;

    logic                    in_valid_reg;
    logic [1:0]              op_reg;
    logic [INDEX_W-1:0]      index_reg;
    logic [BYTE_W-1:0]       value_reg;
    logic [ADDR_W-1:0]       base_reg;
    logic                    out_valid_reg;
    logic [ADDR_W-1:0]       match_address_reg;
    logic [LEN_W-1:0]        len_reg;
    logic [LEN_W-1:0]        len_next;
    logic [CMP_W-1:0]        cfg_ext;

    logic                               advance;
    logic                               step_valid;
    step_t                              step;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] pattern;
    logic                               match;
    logic [ADDR_W-1:0]                  address;

    assign advance    = !out_valid_reg || out_ready;
    assign in_ready   = !in_valid_reg || advance;
    assign step_valid = in_valid_reg && advance;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        step       = '0;
        step.index = index_reg;
        step.value = value_reg;
        step.base  = base_reg;
        unique case (op_reg)
            OP_LOAD:  step.load  = 1'b1;
            OP_START: step.start = 1'b1;
            OP_DATA:  step.data  = 1'b1;
            default:  step.load  = 1'b0;
        endcase
    end

    // length is clamped once, at the write
    always_comb
    begin
        cfg_ext = CMP_W'(pattern_length);
        if (cfg_ext == '0)
        begin
            len_next = LEN_W'(1);
        end
        else if (cfg_ext > CMP_W'(MAX_PATTERN))
        begin
            len_next = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            len_next = LEN_W'(cfg_ext);
        end
    end

    bps_pattern_store #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_store (
        .clk      (clk),
        .wr_en    (step_valid && step.load),
        .wr_index (step.index),
        .wr_value (step.value),
        .pattern  (pattern)
    );

    bps_matcher #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W)
    ) u_matcher (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (step_valid),
        .step       (step),
        .len        (len_reg),
        .pattern    (pattern),
        .match      (match),
        .address    (address)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            len_reg       <= LEN_W'(1);
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= step_valid && match;
            end
            if (cfg_valid && cfg_ready)
            begin
                len_reg <= len_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg    <= opcode;
            index_reg <= pattern_index;
            value_reg <= byte_value;
            base_reg  <= region_base;
        end
        if (step_valid && match)
        begin
            match_address_reg <= address;
        end
    end

    assign out_valid     = out_valid_reg;
    assign match_address = match_address_reg;

endmodule

`default_nettype wire

// ----- sv/bps_checker.sv -----
// port-level checks for the byte pattern search unit, bound to the top level
`default_nettype none

module bps_checker
    import bps_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic [1:0]          opcode,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic [ADDR_W-1:0]   match_address
);

    // a waiting result holds its address
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(match_address))
    else $error("result changed while stalled");

    // a fresh result follows a data byte taken through the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && (opcode == OP_DATA), 2))
    else $error("result without a data transaction");

    // with the result register free the input side must take items
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("input stalled with output free");

    assert property (@(posedge clk)
        !rst_n |=> !out_valid)
    else $error("result shown during reset");

endmodule

bind byte_pattern_search_all_matches_unit bps_checker u_checker (.*);

`default_nettype wire
